// ===== rtl/core/depth_cloud_obstacle_steering_core_macros.svh =====
// Assertion macros for the obstacle steering core.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef DEPTH_CLOUD_OBSTACLE_STEERING_CORE_MACROS_SVH
`define DEPTH_CLOUD_OBSTACLE_STEERING_CORE_MACROS_SVH

// Check a condition on every clock edge outside reset.
`define DCOS_CHECK_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define DCOS_CHECK_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/dcos_pkg.sv =====
// Shared types, constants and helpers of the obstacle steering core.
// No dependencies; used by every module of the core.
`timescale 1ns / 1ps

package dcos_pkg;

    // Depth limits in mm
    localparam int FAR_DEPTH       = 1500;
    localparam int CLOSE_DEPTH     = 800;
    localparam int TOO_CLOSE_DEPTH = 400;
    localparam int TURN_DEPTH      = 1000;
    localparam int MAX_POINTS      = 1048576;

    localparam int CNT_W   = 21;
    localparam int CNT_TOP = (1 << CNT_W) - 1;
    localparam logic [CNT_W-1:0] CNT_CAP =
        CNT_W'((MAX_POINTS < CNT_TOP) ? MAX_POINTS : CNT_TOP);

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_X      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DEPTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_BLOB   = 3'd5;

    // Motion codes
    localparam logic [1:0] MOT_FWD   = 2'd0;
    localparam logic [1:0] MOT_REV   = 2'd1;
    localparam logic [1:0] MOT_CREEP = 2'd2;
    localparam logic [1:0] MOT_SPIN  = 2'd3;

    // Turn direction codes
    localparam logic signed [1:0] DIR_NONE  = 2'sd0;
    localparam logic signed [1:0] DIR_RIGHT = 2'sd1;
    localparam logic signed [1:0] DIR_LEFT  = -2'sd1;

    // Queue between classifier and accumulator
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef struct packed {
        logic signed [15:0] min_x;
        logic signed [15:0] max_x;
        logic signed [15:0] min_height;
        logic signed [15:0] max_height;
        logic [14:0]        min_depth;
        logic [20:0]        min_blob;
    } cfg_t;

    // One classified point: which counters it bumps, and the frame mark
    typedef struct packed {
        logic far_hit;
        logic close_hit;
        logic vclose_hit;
        logic left_hit;
        logic right_hit;
        logic last;
    } class_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c,
                                                 input logic hit);
        logic [CNT_W-1:0] r;
        r = c;
        if (hit && (c < CNT_CAP))
        begin
            r = c + CNT_W'(1);
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/dcos_front.sv =====
// Point classifier: box and depth-band tests for one point.
// Depends on dcos_pkg.
`timescale 1ns / 1ps

module dcos_front (
    input  logic signed [15:0] px,
    input  logic signed [15:0] py,
    input  logic signed [15:0] pz,
    input  logic               point_valid,
    input  logic               frame_end,
    input  dcos_pkg::cfg_t     cfg,
    output dcos_pkg::class_t   cls
);

    localparam logic signed [16:0] FAR_LIM   = 17'(dcos_pkg::FAR_DEPTH);
    localparam logic signed [16:0] CLOSE_LIM = 17'(dcos_pkg::CLOSE_DEPTH);
    localparam logic signed [16:0] VCLS_LIM  = 17'(dcos_pkg::TOO_CLOSE_DEPTH);
    localparam logic signed [16:0] TURN_LIM  = 17'(dcos_pkg::TURN_DEPTH);

    logic signed [16:0] x;
    logic signed [16:0] h;
    logic signed [16:0] z;
    logic signed [16:0] min_d;
    logic               in_box;
    logic               in_x;
    logic               turn_hit;

    always_comb
    begin
        x     = {px[15], px};
        // negate at 17 bits so that the most negative y stays exact
        h     = -$signed({py[15], py});
        z     = {pz[15], pz};
        min_d = $signed({2'b00, cfg.min_depth});

        in_box = point_valid && (z > min_d)
                 && (h > $signed({cfg.min_height[15], cfg.min_height}))
                 && (h < $signed({cfg.max_height[15], cfg.max_height}));
        in_x   = (x > $signed({cfg.min_x[15], cfg.min_x}))
                 && (x < $signed({cfg.max_x[15], cfg.max_x}));
        turn_hit = in_box && in_x && (z < TURN_LIM);

        cls.far_hit    = in_box && (z < FAR_LIM);
        cls.close_hit  = in_box && in_x && (z < CLOSE_LIM);
        cls.vclose_hit = in_box && in_x && (z < VCLS_LIM);
        cls.left_hit   = turn_hit && px[15];
        cls.right_hit  = turn_hit && !px[15];
        cls.last       = frame_end;
    end

endmodule

// ===== rtl/core/dcos_queue.sv =====
// Short queue of classified points between classifier and accumulator.
// Depends on dcos_pkg.
`timescale 1ns / 1ps

module dcos_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  dcos_pkg::class_t push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output dcos_pkg::class_t pop_data
);

    dcos_pkg::class_t                mem_reg [dcos_pkg::QDEPTH];
    logic [dcos_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [dcos_pkg::QPTR_W-1:0]     wr_ptr_next;
    logic [dcos_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [dcos_pkg::QPTR_W-1:0]     rd_ptr_next;
    logic [dcos_pkg::QPTR_W:0]       count_reg;
    logic [dcos_pkg::QPTR_W:0]       count_next;
    logic                            push_fire;
    logic                            pop_fire;

    always_comb
    begin
        push_ready  = (count_reg != (dcos_pkg::QPTR_W + 1)'(dcos_pkg::QDEPTH));
        pop_valid   = (count_reg != '0);
        pop_data    = mem_reg[rd_ptr_reg];
        push_fire   = push_valid && push_ready;
        pop_fire    = pop_valid && pop_ready;
        wr_ptr_next = push_fire ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop_fire ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire && !pop_fire)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_fire && !push_fire)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/dcos_back.sv =====
// Accumulator and steering decision: saturating counters, per-frame command.
// Depends on dcos_pkg.
`timescale 1ns / 1ps

module dcos_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  dcos_pkg::class_t     item,
    input  logic [20:0]          min_blob,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [1:0]    turn_dir,
    output logic [1:0]           motion
);

    logic [dcos_pkg::CNT_W-1:0] far_reg,    far_next;
    logic [dcos_pkg::CNT_W-1:0] close_reg,  close_next;
    logic [dcos_pkg::CNT_W-1:0] vclose_reg, vclose_next;
    logic [dcos_pkg::CNT_W-1:0] left_reg,   left_next;
    logic [dcos_pkg::CNT_W-1:0] right_reg,  right_next;
    logic                       rot_reg,    rot_next;
    logic                       held_reg,   held_next;
    logic                       oval_reg,   oval_next;
    logic signed [1:0]          dir_reg,    dir_next;
    logic [1:0]                 mot_reg,    mot_next;
    logic [dcos_pkg::CNT_W-1:0] far_inc, close_inc, vclose_inc, left_inc, right_inc;
    logic                       fire;
    logic                       go_left;

    always_comb
    begin
        // a plain point never needs the output slot
        item_ready = !item.last || !oval_reg || out_ready;
        fire       = item_valid && item_ready;

        far_inc    = dcos_pkg::sat_inc(far_reg, item.far_hit);
        close_inc  = dcos_pkg::sat_inc(close_reg, item.close_hit);
        vclose_inc = dcos_pkg::sat_inc(vclose_reg, item.vclose_hit);
        left_inc   = dcos_pkg::sat_inc(left_reg, item.left_hit);
        right_inc  = dcos_pkg::sat_inc(right_reg, item.right_hit);

        go_left = rot_reg ? held_reg : (left_inc > right_inc);

        far_next    = far_reg;
        close_next  = close_reg;
        vclose_next = vclose_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        rot_next    = rot_reg;
        held_next   = held_reg;
        dir_next    = dir_reg;
        mot_next    = mot_reg;
        oval_next   = oval_reg && !out_ready;

        if (fire)
        begin
            if (item.last)
            begin
                far_next    = '0;
                close_next  = '0;
                vclose_next = '0;
                left_next   = '0;
                right_next  = '0;
                oval_next   = 1'b1;
                if (far_inc <= min_blob)
                begin
                    mot_next = dcos_pkg::MOT_REV;
                    dir_next = dcos_pkg::DIR_NONE;
                    rot_next = 1'b0;
                end
                else if (close_inc <= min_blob)
                begin
                    mot_next = dcos_pkg::MOT_FWD;
                    dir_next = dcos_pkg::DIR_NONE;
                    rot_next = 1'b0;
                end
                else
                begin
                    held_next = go_left;
                    dir_next  = go_left ? dcos_pkg::DIR_LEFT : dcos_pkg::DIR_RIGHT;
                    mot_next  = (vclose_inc > min_blob) ? dcos_pkg::MOT_SPIN
                                                        : dcos_pkg::MOT_CREEP;
                    rot_next  = 1'b1;
                end
            end
            else
            begin
                far_next    = far_inc;
                close_next  = close_inc;
                vclose_next = vclose_inc;
                left_next   = left_inc;
                right_next  = right_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            far_reg    <= '0;
            close_reg  <= '0;
            vclose_reg <= '0;
            left_reg   <= '0;
            right_reg  <= '0;
            rot_reg    <= 1'b0;
            held_reg   <= 1'b0;
            oval_reg   <= 1'b0;
        end
        else
        begin
            far_reg    <= far_next;
            close_reg  <= close_next;
            vclose_reg <= vclose_next;
            left_reg   <= left_next;
            right_reg  <= right_next;
            rot_reg    <= rot_next;
            held_reg   <= held_next;
            oval_reg   <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dir_reg <= dir_next;
        mot_reg <= mot_next;
    end

    assign out_valid = oval_reg;
    assign turn_dir  = dir_reg;
    assign motion    = mot_reg;

endmodule

// ===== rtl/core/depth_cloud_obstacle_steering_core.sv =====
// Top level of the obstacle steering core: configuration registers,
// classifier, queue and accumulator. Depends on dcos_pkg, dcos_front,
// dcos_queue, dcos_back and the assertion macro header.
`timescale 1ns / 1ps
`include "depth_cloud_obstacle_steering_core_macros.svh"

// Usage
//   Input channel (in_valid / in_ready): one depth point per item with
//   px, py, pz in signed mm, point_valid and frame_end. Output channel
//   (out_valid / out_ready): one steering command per frame, given for the
//   item that carries frame_end; turn_dir -1/0/1 and motion code.
//   Configuration: cfg_we with cfg_index and cfg_data writes one register
//   at the clock edge; write only while no frame is in flight.
//   Throughput: one item per cycle while the queue has room, set by the classifier
//   compares and the registered counter update in the accumulator.
//   Path: a frame_end item goes through the queue and is taken by the accumulator,
//   which registers the command and out_valid; items queued before it go first.
//   Reset: counters, turning state and queue clear; registers take their
//   reset values (box 0..20000 on x and height, min depth 0, blob 4000).
//   Stall: while out_ready is low the command holds; plain points keep
//   flowing, a second frame_end waits in the four-entry queue, and
//   in_ready drops only when that queue fills.
module depth_cloud_obstacle_steering_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [15:0]                  px,
    input  logic signed [15:0]                  py,
    input  logic signed [15:0]                  pz,
    input  logic                                point_valid,
    input  logic                                frame_end,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [1:0]                   turn_dir,
    output logic [1:0]                          motion,
    input  logic                                cfg_we,
    input  logic [dcos_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dcos_pkg::CFG_DATA_W-1:0]     cfg_data
);

    dcos_pkg::cfg_t   cfg_reg;
    dcos_pkg::cfg_t   cfg_next;
    dcos_pkg::class_t cls;
    dcos_pkg::class_t q_item;
    logic             q_valid;
    logic             q_ready;
    logic             turn_match;

    // Register file: decode the index, drop writes beyond the list and
    // any data bits above a register's width.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                dcos_pkg::REG_MIN_X:      cfg_next.min_x      = cfg_data[15:0];
                dcos_pkg::REG_MAX_X:      cfg_next.max_x      = cfg_data[15:0];
                dcos_pkg::REG_MIN_HEIGHT: cfg_next.min_height = cfg_data[15:0];
                dcos_pkg::REG_MAX_HEIGHT: cfg_next.max_height = cfg_data[15:0];
                dcos_pkg::REG_MIN_DEPTH:  cfg_next.min_depth  = cfg_data[14:0];
                dcos_pkg::REG_MIN_BLOB:   cfg_next.min_blob   = cfg_data[20:0];
                default:                  cfg_next            = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_x      <= 16'sd0;
            cfg_reg.max_x      <= 16'sd20000;
            cfg_reg.min_height <= 16'sd0;
            cfg_reg.max_height <= 16'sd20000;
            cfg_reg.min_depth  <= 15'd0;
            cfg_reg.min_blob   <= 21'd4000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: classify each point as it arrives
    dcos_front u_front (
        .px          (px),
        .py          (py),
        .pz          (pz),
        .point_valid (point_valid),
        .frame_end   (frame_end),
        .cfg         (cfg_reg),
        .cls         (cls)
    );

    // Queue: decouple the classifier from the accumulator
    dcos_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_ready (in_ready),
        .push_data  (cls),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_item)
    );

    // Back: count hits and issue the command at frame end
    dcos_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .item       (q_item),
        .min_blob   (cfg_reg.min_blob),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .turn_dir   (turn_dir),
        .motion     (motion)
    );

    // Creep and spin carry a direction, forward and reverse carry none
    assign turn_match = ((motion == dcos_pkg::MOT_CREEP) || (motion == dcos_pkg::MOT_SPIN))
                        == (turn_dir != dcos_pkg::DIR_NONE);

    // A command never carries the unused direction code
    `DCOS_CHECK_IMPLY(a_dir_code, out_valid, turn_dir != 2'sb10, "bad turn_dir code")
    // A turn is given exactly when the motion is creep or spin
    `DCOS_CHECK_IMPLY(a_turn_motion, out_valid, turn_match, "turn_dir disagrees with motion")
    // A full queue always offers an item to the accumulator
    `DCOS_CHECK_IMPLY(a_full_has_item, !in_ready, q_valid, "queue full but empty at output")

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for depth_cloud_obstacle_steering_core: drives depth points
// and register writes, predicts every steering command and compares it field by field.
// Depends on dcos_pkg and the core RTL only.
`timescale 1ns / 1ps

module testbench;
    import dcos_pkg::*;

    localparam int HALF_PERIOD      = 10;
    // cycles to let plain points drain out of the queue before a register write
    localparam int SETTLE_CYCLES    = 12;
    localparam int HOLD_CYCLES      = 120;
    localparam int STALL_LIMIT      = 4000;
    localparam int PHASES_PER_MODE  = 4;
    localparam int POINTS_PER_PHASE = 130;
    localparam int COUNT_CEILING    =
        (MAX_POINTS < (1 << CNT_W) - 1) ? MAX_POINTS : (1 << CNT_W) - 1;
    // indexes past the register list: the core must ignore writes to them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               ok;
        logic               last;
    } point_t;

    typedef struct {
        logic signed [1:0] dir;
        logic [1:0]        mot;
    } steer_t;

    // One row of the directed table: either a register write or a point,
    // the latter with an optional hand-typed command
    typedef struct {
        bit                    is_reg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        point_t                pt;
        bit                    typed;
        steer_t                cmd;
    } plan_row_t;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic                  in_ready;
    logic signed [15:0]    px          = '0;
    logic signed [15:0]    py          = '0;
    logic signed [15:0]    pz          = '0;
    logic                  point_valid = 1'b0;
    logic                  frame_end   = 1'b0;
    logic                  out_valid;
    logic                  out_ready   = 1'b0;
    logic signed [1:0]     turn_dir;
    logic [1:0]            motion;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;

    // Steering model: its own copy of the box registers, counters and turn memory
    cfg_t   box;
    int     far_n, close_n, vclose_n, left_n, right_n;
    bit     turning;
    bit     keep_left;
    steer_t pending_cmds[$];

    int mismatches     = 0;
    int points_sent    = 0;
    int frames_sent    = 0;
    int settings_used  = 0;
    int motion_seen[4] = '{0, 0, 0, 0};
    int tx_idle_pct    = 0;
    int rx_idle_pct    = 0;
    int holds_asked    = 0;
    int holds_given    = 0;
    int hold_left      = 0;
    int idle_cycles    = 0;

    depth_cloud_obstacle_steering_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .px          (px),
        .py          (py),
        .pz          (pz),
        .point_valid (point_valid),
        .frame_end   (frame_end),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .turn_dir    (turn_dir),
        .motion      (motion),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Steering model
    // ------------------------------------------------------------------
    function automatic void clear_counts();
        far_n    = 0;
        close_n  = 0;
        vclose_n = 0;
        left_n   = 0;
        right_n  = 0;
    endfunction

    function automatic void reset_model();
        box.min_x      = 16'sd0;
        box.max_x      = 16'sd20000;
        box.min_height = 16'sd0;
        box.max_height = 16'sd20000;
        box.min_depth  = 15'd0;
        box.min_blob   = 21'd4000;
        clear_counts();
        turning   = 1'b0;
        keep_left = 1'b0;
    endfunction

    // Bits above a register's width are dropped; unknown indexes change nothing
    function automatic void set_box_reg(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_MIN_X:      box.min_x      = data[15:0];
            REG_MAX_X:      box.max_x      = data[15:0];
            REG_MIN_HEIGHT: box.min_height = data[15:0];
            REG_MAX_HEIGHT: box.max_height = data[15:0];
            REG_MIN_DEPTH:  box.min_depth  = data[14:0];
            REG_MIN_BLOB:   box.min_blob   = data[20:0];
            default: ;
        endcase
    endfunction

    function automatic int bump(input int c);
        return (c < COUNT_CEILING) ? c + 1 : c;
    endfunction

    // Count one point, and on the frame mark decide the command and clear the counters
    function automatic void steer_on_point(input point_t p, output bit gives,
                                           output steer_t cmd);
        int x, h, z, blob;
        bit in_x;
        x     = p.x;
        h     = -int'(p.y);      // height is -y at full range: y = -32768 gives +32768
        z     = p.z;
        blob  = box.min_blob;
        gives = 1'b0;
        cmd.dir = DIR_NONE;
        cmd.mot = MOT_FWD;
        if (p.ok && z > int'(box.min_depth) && h > int'($signed(box.min_height))
            && h < int'($signed(box.max_height)))
        begin
            in_x = x > int'($signed(box.min_x)) && x < int'($signed(box.max_x));
            if (z < FAR_DEPTH)
                far_n = bump(far_n);
            if (in_x)
            begin
                if (z < CLOSE_DEPTH)
                    close_n = bump(close_n);
                if (z < TOO_CLOSE_DEPTH)
                    vclose_n = bump(vclose_n);
                if (z < TURN_DEPTH)
                begin
                    if (x < 0)
                        left_n = bump(left_n);
                    else
                        right_n = bump(right_n);
                end
            end
        end
        if (p.last)
        begin
            gives = 1'b1;
            if (far_n <= blob)
            begin
                cmd.mot = MOT_REV;
                turning = 1'b0;
            end
            else if (close_n <= blob)
            begin
                cmd.mot = MOT_FWD;
                turning = 1'b0;
            end
            else
            begin
                // pick a side only when a turn starts; ties go right
                if (!turning)
                    keep_left = left_n > right_n;
                cmd.dir = keep_left ? DIR_LEFT : DIR_RIGHT;
                cmd.mot = (vclose_n > blob) ? MOT_SPIN : MOT_CREEP;
                turning = 1'b1;
            end
            clear_counts();
        end
    endfunction

    // ------------------------------------------------------------------
    // Directed table rows
    // ------------------------------------------------------------------
    function automatic plan_row_t point_row(input int x, input int y, input int z,
                                            input bit ok, input bit last);
        plan_row_t r;
        r.is_reg  = 1'b0;
        r.idx     = '0;
        r.data    = '0;
        r.pt.x    = 16'(x);
        r.pt.y    = 16'(y);
        r.pt.z    = 16'(z);
        r.pt.ok   = ok;
        r.pt.last = last;
        r.typed   = 1'b0;
        r.cmd.dir = DIR_NONE;
        r.cmd.mot = MOT_FWD;
        return r;
    endfunction

    function automatic plan_row_t command_row(input int x, input int y, input int z,
                                              input bit ok, input bit last,
                                              input logic signed [1:0] dir,
                                              input logic [1:0] mot);
        plan_row_t r;
        r         = point_row(x, y, z, ok, last);
        r.typed   = 1'b1;
        r.cmd.dir = dir;
        r.cmd.mot = mot;
        return r;
    endfunction

    function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        plan_row_t r;
        r        = point_row(0, 0, 0, 1'b0, 1'b0);
        r.is_reg = 1'b1;
        r.idx    = idx;
        r.data   = data;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Drive the write up to a clock edge and update the model; the caller drops cfg_we after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        set_box_reg(idx, data);
    endtask

    // Offer one point, idling first at the current rate, and log its command on acceptance
    task automatic send_point(input point_t p, input bit typed,
                              input logic signed [1:0] tdir, input logic [1:0] tmot);
        bit     gives;
        steer_t cmd;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        px          <= p.x;
        py          <= p.y;
        pz          <= p.z;
        point_valid <= p.ok;
        frame_end   <= p.last;
        do
            @(posedge clk);
        while (!in_ready);
        steer_on_point(p, gives, cmd);
        if (gives)
        begin
            if (typed)
            begin
                cmd.dir = tdir;
                cmd.mot = tmot;
            end
            pending_cmds.push_back(cmd);
            frames_sent++;
        end
        points_sent++;
    endtask

    // Drop valid, wait for every outstanding command, then let the pipe empty
    task automatic wait_for_commands();
        in_valid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly points of a plausible scene in front of the camera; some pure noise
    // over the whole 16-bit range and some not-a-number points
    function automatic point_t scene_point(input int z_top, input int x_shift);
        point_t p;
        int     pick;
        pick   = $urandom_range(99);
        p.ok   = 1'b1;
        p.last = 1'b0;
        if (pick < 10)
        begin
            p.x = 16'($urandom);
            p.y = 16'($urandom);
            p.z = 16'($urandom);
        end
        else
        begin
            p.x = 16'($urandom_range(0, 1600) - x_shift);
            p.y = 16'($urandom_range(0, 1800) - 1300);
            p.z = 16'($urandom_range(0, z_top));
            if (pick < 16)
                p.ok = 1'b0;
        end
        return p;
    endfunction

    // One frame: depth reach and sideways skew drawn once, so frames lean to a side
    task automatic send_frame(input int len);
        point_t p;
        int     z_top;
        int     x_shift;
        case ($urandom_range(3))
            0:       z_top = 1800;
            1:       z_top = 1100;
            2:       z_top = 850;
            default: z_top = 450;
        endcase
        x_shift = $urandom_range(400, 1200);
        for (int i = 0; i < len; i++)
        begin
            p      = scene_point(z_top, x_shift);
            p.last = (i == len - 1);
            send_point(p, 1'b0, DIR_NONE, MOT_FWD);
        end
    endtask

    // Box around the scene with junk in the unused upper bits; now and then a
    // register gets a fully random word instead
    task automatic program_random_box();
        logic [CFG_DATA_W-1:0] val [6];
        val[REG_MIN_X]      = {5'($urandom), 16'(-$urandom_range(0, 800))};
        val[REG_MAX_X]      = {5'($urandom), 16'($urandom_range(0, 800))};
        val[REG_MIN_HEIGHT] = {5'($urandom), 16'(-$urandom_range(0, 400))};
        val[REG_MAX_HEIGHT] = {5'($urandom), 16'($urandom_range(300, 1400))};
        val[REG_MIN_DEPTH]  = {6'($urandom), 15'($urandom_range(0, 200))};
        val[REG_MIN_BLOB]   = 21'($urandom_range(0, 6));
        foreach (val[i])
            if ($urandom_range(7) == 0)
                val[i] = 21'($urandom);
        write_reg(REG_MIN_X, val[REG_MIN_X]);
        write_reg(REG_MAX_X, val[REG_MAX_X]);
        write_reg(REG_MIN_HEIGHT, val[REG_MIN_HEIGHT]);
        write_reg(REG_MAX_HEIGHT, val[REG_MAX_HEIGHT]);
        write_reg(REG_MIN_DEPTH, val[REG_MIN_DEPTH]);
        write_reg(REG_MIN_BLOB, val[REG_MIN_BLOB]);
        if ($urandom_range(3) == 0)
            write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, 21'($urandom));
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic void note_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: mismatch: %s", $realtime, what);
    endfunction

    // ------------------------------------------------------------------
    // Receiver: check each accepted command, then drive out_ready. A hold
    // request from the stimulus starts a long stretch with ready low, timed here.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        steer_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_cmds.size() == 0)
            begin
                note_mismatch($sformatf("command with none due: turn_dir %0d motion %0d",
                                        turn_dir, motion));
            end
            else
            begin
                want = pending_cmds.pop_front();
                motion_seen[want.mot]++;
                if (turn_dir !== want.dir || motion !== want.mot)
                    note_mismatch($sformatf("turn_dir exp %0d got %0d, motion exp %0d got %0d",
                                            want.dir, turn_dir, want.mot, motion));
            end
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (holds_given != holds_asked)
        begin
            holds_given = holds_asked;
            hold_left   = HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog: end the run if no handshake or write happens for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles, %0d commands still due",
                     $realtime, STALL_LIMIT, pending_cmds.size());
            $display("[depth_cloud_obstacle_steering_core] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        plan_row_t plan[$];
        int        target;

        reset_model();

        // At reset values: a lone near point is far below the blob size, so reverse
        plan.push_back(command_row(100, -100, 500, 1'b1, 1'b1, DIR_NONE, MOT_REV));
        // Open the box fully, blob size zero; junk above the register widths,
        // and writes past the end of the register list that must be ignored
        plan.push_back(reg_row(REG_MIN_BLOB, 21'h000000));
        plan.push_back(reg_row(REG_MIN_X, 21'h1F8000));
        plan.push_back(reg_row(REG_MAX_X, 21'h0A7FFF));
        plan.push_back(reg_row(REG_MIN_HEIGHT, 21'h158000));
        plan.push_back(reg_row(REG_MAX_HEIGHT, 21'h007FFF));
        plan.push_back(reg_row(REG_MIN_DEPTH, 21'h1F8000));
        plan.push_back(reg_row(REG_SPARE_LO, 21'h1FFFFF));
        plan.push_back(reg_row(REG_SPARE_HI, 21'h155555));
        // Field extremes that fall outside the exclusive limits
        plan.push_back(point_row(-32768, 32767, 32767, 1'b1, 1'b0));
        plan.push_back(point_row(32767, -32767, -32768, 1'b1, 1'b0));
        plan.push_back(point_row(-5, 0, 300, 1'b0, 1'b0));
        // Very close on the left: start a left spin
        plan.push_back(command_row(-5, 0, 300, 1'b1, 1'b1, DIR_LEFT, MOT_SPIN));
        // Still turning: keep left although the point is now on the right
        plan.push_back(command_row(5, 0, 300, 1'b1, 1'b1, DIR_LEFT, MOT_SPIN));
        // Only a far point: forward, turn ends
        plan.push_back(command_row(0, 0, 1200, 1'b1, 1'b1, DIR_NONE, MOT_FWD));
        // Left and right level: turn right at creep
        plan.push_back(point_row(-5, 0, 600, 1'b1, 1'b0));
        plan.push_back(command_row(5, 0, 600, 1'b1, 1'b1, DIR_RIGHT, MOT_CREEP));
        // Not-a-number point carrying the frame mark: not counted, command still given
        plan.push_back(command_row(-5, 0, 300, 1'b0, 1'b1, DIR_NONE, MOT_REV));
        // Most negative y gives a height of +32768, above every limit
        plan.push_back(command_row(1, -32768, 100, 1'b1, 1'b1, DIR_NONE, MOT_REV));
        // Depths on each side of every limit, x at zero and just below
        plan.push_back(point_row(0, 0, 0, 1'b1, 1'b0));
        plan.push_back(point_row(0, 0, 1499, 1'b1, 1'b0));
        plan.push_back(point_row(0, 0, 799, 1'b1, 1'b0));
        plan.push_back(point_row(-1, 0, 399, 1'b1, 1'b0));
        plan.push_back(point_row(0, 0, 999, 1'b1, 1'b0));
        plan.push_back(point_row(0, 0, 1000, 1'b1, 1'b0));
        plan.push_back(point_row(-1, 0, 800, 1'b1, 1'b0));
        plan.push_back(point_row(0, 0, 800, 1'b1, 1'b1));
        // Empty box, top depth and a blob size at the counter ceiling: always reverse
        plan.push_back(reg_row(REG_MIN_BLOB, 21'h100000));
        plan.push_back(reg_row(REG_MIN_DEPTH, 21'h1FFFFF));
        plan.push_back(reg_row(REG_MIN_X, 21'h0E7FFF));
        plan.push_back(reg_row(REG_MAX_X, 21'h008000));
        plan.push_back(reg_row(REG_MIN_HEIGHT, 21'h107FFF));
        plan.push_back(reg_row(REG_MAX_HEIGHT, 21'h1F8000));
        plan.push_back(command_row(0, 0, 100, 1'b1, 1'b1, DIR_NONE, MOT_REV));

        tx_idle_pct = 24;
        rx_idle_pct = 47;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the table; drain the core before each group of writes
        for (int i = 0; i < plan.size(); i++)
        begin
            if (plan[i].is_reg)
            begin
                if (i > 0 && !plan[i-1].is_reg)
                    wait_for_commands();
                write_reg(plan[i].idx, plan[i].data);
            end
            else
            begin
                if (i > 0 && plan[i-1].is_reg)
                    cfg_we <= 1'b0;
                send_point(plan[i].pt, plan[i].typed, plan[i].cmd.dir, plan[i].cmd.mot);
            end
        end
        settings_used = 3;

        // Random frames under three handshake mixes, new box settings per phase
        for (int mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:
                begin
                    tx_idle_pct = 24;
                    rx_idle_pct = 47;
                end
                1:
                begin
                    tx_idle_pct = 47;
                    rx_idle_pct = 24;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (int phase = 0; phase < PHASES_PER_MODE; phase++)
            begin
                wait_for_commands();
                program_random_box();
                target = points_sent + POINTS_PER_PHASE;
                if (mode == 2 && phase == 0)
                begin
                    // Hold the receiver off while one- and two-point frames pour in,
                    // so the core's point queue fills and the input stalls
                    holds_asked++;
                    while (points_sent < target)
                        send_frame($urandom_range(1, 2));
                end
                else
                begin
                    while (points_sent < target)
                    begin
                        send_frame(($urandom_range(9) == 0) ? 1 : $urandom_range(2, 24));
                        if ($urandom_range(15) == 0)
                            wait_for_commands();
                    end
                end
            end
        end

        wait_for_commands();
        mismatches += pending_cmds.size();
        $display("Run covered %0d points in %0d frames over %0d box settings, three handshake mixes",
                 points_sent, frames_sent, settings_used);
        $display("Commands seen: forward %0d, reverse %0d, creep %0d, spin %0d; mismatches %0d",
                 motion_seen[MOT_FWD], motion_seen[MOT_REV], motion_seen[MOT_CREEP],
                 motion_seen[MOT_SPIN], mismatches);
        if (mismatches == 0)
            $display("[depth_cloud_obstacle_steering_core] OK");
        else
            $display("[depth_cloud_obstacle_steering_core] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/dcos_pkg.sv
rtl/core/dcos_front.sv
rtl/core/dcos_queue.sv
rtl/core/dcos_back.sv
rtl/core/depth_cloud_obstacle_steering_core.sv
sim/testbench.sv
